FILE: hdl/ycrgb_pkg.sv
`timescale 1ns / 1ps

package ycrgb_pkg;

   // register map, one 32-bit word per register
   localparam int CSR_AW = 5;
   localparam logic [2:0] REG_SUBSAMPLING_MODE = 3'd0;
   localparam logic [2:0] REG_LINE_WIDTH       = 3'd1;
   localparam logic [2:0] REG_FRAME_HEIGHT     = 3'd2;
   localparam logic [2:0] REG_SAMPLE_PRECISION = 3'd3;
   localparam logic [2:0] REG_ODD_START_COLUMN = 3'd4;
   localparam logic [2:0] REG_ODD_START_ROW    = 3'd5;

   localparam logic [1:0] MODE_444  = 2'd0;
   localparam logic [1:0] MODE_422  = 2'd1;
   localparam logic [1:0] MODE_420  = 2'd2;
   localparam logic [1:0] MODE_RSVD = 2'd3;

   // q16 conversion coefficients
   localparam logic signed [17:0] COEF_R_CR = 18'sd91881;
   localparam logic signed [17:0] COEF_G_CB = 18'sd22544;
   localparam logic signed [17:0] COEF_G_CR = 18'sd46793;
   localparam logic signed [17:0] COEF_B_CB = 18'sd116130;

   localparam int OUTQ_DEPTH = 8;
   localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

   typedef struct packed {
      logic [1:0]  subsampling_mode;
      logic [12:0] line_width;
      logic [15:0] frame_height;
      logic [4:0]  sample_precision;
      logic        odd_start_column;
      logic        odd_start_row;
   } cfg_type;

   typedef struct packed {
      logic [15:0] luma;
      logic [15:0] blue_diff;
      logic [15:0] red_diff;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic        chroma_taken;
      logic        frame_end;
   } rsp_payload_type;

   // pixel with its resolved chroma pair
   typedef struct packed {
      logic [15:0] luma;
      logic [15:0] cb;
      logic [15:0] cr;
      logic        taken;
      logic        frame_end;
   } pix_type;

endpackage

FILE: hdl/ycrgb_csr.sv
`timescale 1ns / 1ps

module ycrgb_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [ycrgb_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready,
   output ycrgb_pkg::cfg_type           cfg
);

   ycrgb_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            ycrgb_pkg::REG_SUBSAMPLING_MODE: cfg_in.subsampling_mode = csr_pwdata[1:0];
            ycrgb_pkg::REG_LINE_WIDTH:       cfg_in.line_width       = csr_pwdata[12:0];
            ycrgb_pkg::REG_FRAME_HEIGHT:     cfg_in.frame_height     = csr_pwdata[15:0];
            ycrgb_pkg::REG_SAMPLE_PRECISION: cfg_in.sample_precision = csr_pwdata[4:0];
            ycrgb_pkg::REG_ODD_START_COLUMN: cfg_in.odd_start_column = csr_pwdata[0];
            ycrgb_pkg::REG_ODD_START_ROW:    cfg_in.odd_start_row    = csr_pwdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         ycrgb_pkg::REG_SUBSAMPLING_MODE: csr_prdata = {30'd0, cfg_ff.subsampling_mode};
         ycrgb_pkg::REG_LINE_WIDTH:       csr_prdata = {19'd0, cfg_ff.line_width};
         ycrgb_pkg::REG_FRAME_HEIGHT:     csr_prdata = {16'd0, cfg_ff.frame_height};
         ycrgb_pkg::REG_SAMPLE_PRECISION: csr_prdata = {27'd0, cfg_ff.sample_precision};
         ycrgb_pkg::REG_ODD_START_COLUMN: csr_prdata = {31'd0, cfg_ff.odd_start_column};
         ycrgb_pkg::REG_ODD_START_ROW:    csr_prdata = {31'd0, cfg_ff.odd_start_row};
         default:                         csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.subsampling_mode <= ycrgb_pkg::MODE_444;
         cfg_ff.line_width       <= 13'd1;
         cfg_ff.frame_height     <= 16'd1;
         cfg_ff.sample_precision <= 5'd8;
         cfg_ff.odd_start_column <= 1'b0;
         cfg_ff.odd_start_row    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hdl/ycrgb_chroma.sv
`timescale 1ns / 1ps

module ycrgb_chroma #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ycrgb_pkg::cfg_type         cfg,
   input  logic                       in_valid,
   input  ycrgb_pkg::req_payload_type in_data,
   output logic                       out_valid,
   output ycrgb_pkg::pix_type         out_pix
);

   localparam int CW         = $clog2(MAX_WIDTH);
   localparam int WW         = CW + 1;
   localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

   logic [CW-1:0] col_ff, col_in;
   logic [15:0]   row_ff, row_in;
   logic [31:0]   held_ff, held_in;

   logic [31:0]   line_mem [LINE_DEPTH];
   logic [31:0]   line_rd_ff;

   logic          s1_valid_ff;
   logic [15:0]   s1_luma_ff;
   logic [15:0]   s1_cb_ff, s1_cb_in;
   logic [15:0]   s1_cr_ff, s1_cr_in;
   logic          s1_line_ff;
   logic          s1_taken_ff;
   logic          s1_end_ff;

   logic [WW-1:0] w_eff;
   logic [15:0]   h_eff;
   logic [1:0]    mode_eff;
   logic          col_wrap;
   logic [16:0]   row_a;
   logic [CW-1:0] col_cur;
   logic [15:0]   row_cur;
   logic [WW-1:0] col_inc;
   logic [16:0]   row_inc;
   logic          frame_end;
   logic          off_x, off_y;
   logic [CW-1:0] cc;
   logic          rr_odd;
   logic [LINE_AW-1:0] line_addr;
   logic          taken, use_zero, use_line, use_held, site_take;
   logic          line_we, line_re;

   // effective sizes and mode
   always_comb begin
      if (cfg.line_width == 13'd0) begin
         w_eff = WW'(1);
      end else if (32'(cfg.line_width) > 32'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(cfg.line_width);
      end
      h_eff = (cfg.frame_height == 16'd0) ? 16'd1 : cfg.frame_height;
      case (cfg.subsampling_mode)
         ycrgb_pkg::MODE_422: mode_eff = ycrgb_pkg::MODE_422;
         ycrgb_pkg::MODE_420: mode_eff = ycrgb_pkg::MODE_420;
         default:             mode_eff = ycrgb_pkg::MODE_444;
      endcase
   end

   // position of this pixel, after a possible size change
   always_comb begin
      col_wrap = {1'b0, col_ff} >= w_eff;
      row_a    = col_wrap ? ({1'b0, row_ff} + 17'd1) : {1'b0, row_ff};
      row_cur  = (row_a >= {1'b0, h_eff}) ? 16'd0 : row_a[15:0];
      col_cur  = col_wrap ? '0 : col_ff;
      col_inc  = {1'b0, col_cur} + WW'(1);
      row_inc  = {1'b0, row_cur} + 17'd1;
      frame_end = ({1'b0, col_cur} == (w_eff - WW'(1))) && (row_cur == (h_eff - 16'd1));

      col_in = col_ff;
      row_in = row_ff;
      if (in_valid) begin
         if (col_inc >= w_eff) begin
            col_in = '0;
            row_in = (row_inc >= {1'b0, h_eff}) ? 16'd0 : row_inc[15:0];
         end else begin
            col_in = col_inc[CW-1:0];
            row_in = row_cur;
         end
      end
   end

   // chroma site decision
   always_comb begin
      off_x     = (mode_eff != ycrgb_pkg::MODE_444) && cfg.odd_start_column;
      off_y     = (mode_eff == ycrgb_pkg::MODE_420) && cfg.odd_start_row;
      cc        = col_cur - CW'(off_x);
      rr_odd    = row_cur[0] ^ off_y;
      line_addr = LINE_AW'(cc >> 1);

      taken     = 1'b0;
      use_zero  = 1'b0;
      use_line  = 1'b0;
      use_held  = 1'b0;
      site_take = 1'b0;
      if (mode_eff == ycrgb_pkg::MODE_444) begin
         taken = 1'b1;
      end else if ((off_x && col_cur == '0) || (off_y && row_cur == 16'd0)) begin
         use_zero = 1'b1;
      end else if (mode_eff == ycrgb_pkg::MODE_420 && rr_odd) begin
         use_line = 1'b1;
      end else if (!cc[0]) begin
         taken     = 1'b1;
         site_take = 1'b1;
      end else begin
         use_held = 1'b1;
      end

      line_we = in_valid && site_take && (mode_eff == ycrgb_pkg::MODE_420);
      line_re = in_valid && use_line;
      held_in = (in_valid && site_take) ? {in_data.red_diff, in_data.blue_diff} : held_ff;

      if (use_zero) begin
         s1_cb_in = 16'd0;
         s1_cr_in = 16'd0;
      end else if (use_held) begin
         s1_cb_in = held_ff[15:0];
         s1_cr_in = held_ff[31:16];
      end else begin
         s1_cb_in = in_data.blue_diff;
         s1_cr_in = in_data.red_diff;
      end
   end

   // line store: at most one access per item, a write on an upper row or a read on a
   // lower row, never both, and the read of an entry comes at a later edge
   always_ff @(posedge clock) begin
      if (line_we) begin
         line_mem[line_addr] <= {in_data.red_diff, in_data.blue_diff};
      end
      if (line_re) begin
         line_rd_ff <= line_mem[line_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= 16'd0;
         held_ff     <= 32'd0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         held_ff     <= held_in;
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         s1_luma_ff  <= in_data.luma;
         s1_cb_ff    <= s1_cb_in;
         s1_cr_ff    <= s1_cr_in;
         s1_line_ff  <= use_line;
         s1_taken_ff <= taken;
         s1_end_ff   <= frame_end;
      end
   end

   assign out_valid         = s1_valid_ff;
   assign out_pix.luma      = s1_luma_ff;
   assign out_pix.cb        = s1_line_ff ? line_rd_ff[15:0] : s1_cb_ff;
   assign out_pix.cr        = s1_line_ff ? line_rd_ff[31:16] : s1_cr_ff;
   assign out_pix.taken     = s1_taken_ff;
   assign out_pix.frame_end = s1_end_ff;

`ifndef NO_ASSERTIONS
   a_line_not_taken: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_line_ff |-> !s1_taken_ff)
      else $error("line store item marked as taking chroma");

   a_write_only_420: assert property (@(posedge clock) disable iff (reset)
      line_we |-> (cfg.subsampling_mode == ycrgb_pkg::MODE_420) && !line_re)
      else $error("line store write outside 4:2:0 or with a read");
`endif

endmodule

FILE: hdl/ycrgb_convert.sv
`timescale 1ns / 1ps

module ycrgb_convert #(
   parameter int MAX_PRECISION = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ycrgb_pkg::cfg_type         cfg,
   input  logic                       in_valid,
   input  ycrgb_pkg::pix_type         in_pix,
   output logic                       out_valid,
   output ycrgb_pkg::rsp_payload_type out_data
);

   localparam int LAT = 4;

   function automatic logic signed [19:0] trunc_q16(input logic signed [35:0] v);
      logic signed [35:0] adj;
      adj = v + (v[35] ? 36'sd65535 : 36'sd0);
      return adj[35:16];
   endfunction

   function automatic logic [15:0] clamp_out(input logic signed [20:0] s,
                                             input logic [15:0] top);
      logic [15:0] r;
      if (s[20]) begin
         r = 16'd0;
      end else if (s[19:0] > {4'd0, top}) begin
         r = top;
      end else begin
         r = s[15:0];
      end
      return r;
   endfunction

   logic [4:0]  p_eff;
   logic [16:0] top_w;
   logic [15:0] top;
   logic [15:0] off;

   logic [LAT-1:0] valid_ff;

   logic [15:0]        y_a_ff, y_b_ff, y_c_ff, y_d_ff;
   logic [1:0]         flag_a_ff, flag_b_ff, flag_c_ff, flag_d_ff;
   logic signed [17:0] cb_a_ff, cr_a_ff;
   logic signed [35:0] prod_r_ff, prod_gb_ff, prod_gr_ff, prod_b_ff;
   logic signed [35:0] sum_r_ff, sum_g_ff, sum_b_ff;
   logic signed [19:0] t_r_ff, t_g_ff, t_b_ff;
   logic signed [20:0] y_s, r_s, g_s, b_s;

   always_comb begin
      if (cfg.sample_precision == 5'd0) begin
         p_eff = 5'd1;
      end else if (cfg.sample_precision > 5'(MAX_PRECISION)) begin
         p_eff = 5'(MAX_PRECISION);
      end else begin
         p_eff = cfg.sample_precision;
      end
      top_w = (17'd1 << p_eff) - 17'd1;
      top   = top_w[15:0];
      off   = 16'(17'd1 << (p_eff - 5'd1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[LAT-2:0], in_valid};
      end
   end

   // a: center chroma, b: multiply, c: sum, d: truncate
   always_ff @(posedge clock) begin
      y_a_ff    <= in_pix.luma;
      flag_a_ff <= {in_pix.taken, in_pix.frame_end};
      cb_a_ff   <= $signed({2'b00, in_pix.cb}) - $signed({2'b00, off});
      cr_a_ff   <= $signed({2'b00, in_pix.cr}) - $signed({2'b00, off});

      y_b_ff     <= y_a_ff;
      flag_b_ff  <= flag_a_ff;
      prod_r_ff  <= cr_a_ff * ycrgb_pkg::COEF_R_CR;
      prod_gb_ff <= cb_a_ff * ycrgb_pkg::COEF_G_CB;
      prod_gr_ff <= cr_a_ff * ycrgb_pkg::COEF_G_CR;
      prod_b_ff  <= cb_a_ff * ycrgb_pkg::COEF_B_CB;

      y_c_ff    <= y_b_ff;
      flag_c_ff <= flag_b_ff;
      sum_r_ff  <= prod_r_ff;
      sum_g_ff  <= prod_gb_ff + prod_gr_ff;
      sum_b_ff  <= prod_b_ff;

      y_d_ff    <= y_c_ff;
      flag_d_ff <= flag_c_ff;
      t_r_ff    <= trunc_q16(sum_r_ff);
      t_g_ff    <= trunc_q16(sum_g_ff);
      t_b_ff    <= trunc_q16(sum_b_ff);
   end

   always_comb begin
      y_s = $signed({5'd0, y_d_ff});
      r_s = y_s + {t_r_ff[19], t_r_ff};
      g_s = y_s - {t_g_ff[19], t_g_ff};
      b_s = y_s + {t_b_ff[19], t_b_ff};
   end

   assign out_valid             = valid_ff[LAT-1];
   assign out_data.red          = clamp_out(r_s, top);
   assign out_data.green        = clamp_out(g_s, top);
   assign out_data.blue         = clamp_out(b_s, top);
   assign out_data.chroma_taken = flag_d_ff[1];
   assign out_data.frame_end    = flag_d_ff[0];

`ifndef NO_ASSERTIONS
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> ##4 out_valid)
      else $error("conversion pipeline lost an item");
`endif

endmodule

FILE: hdl/ycrgb_outq.sv
`timescale 1ns / 1ps

module ycrgb_outq (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_accept,
   input  logic                       push_valid,
   input  ycrgb_pkg::rsp_payload_type push_data,
   output logic                       out_valid,
   output ycrgb_pkg::rsp_payload_type out_data,
   input  logic                       out_stall,
   output logic                       full
);

   ycrgb_pkg::rsp_payload_type q_mem [ycrgb_pkg::OUTQ_DEPTH];

   logic [ycrgb_pkg::OUTQ_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ycrgb_pkg::OUTQ_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ycrgb_pkg::OUTQ_CW-1:0] count_ff, count_in;
   // items accepted at the input and not yet delivered
   logic [ycrgb_pkg::OUTQ_CW-1:0] occ_ff, occ_in;
   logic pop;

   assign out_valid = count_ff != '0;
   assign out_data  = q_mem[rd_ptr_ff];
   assign pop       = out_valid && !out_stall;
   assign full      = occ_ff >= ycrgb_pkg::OUTQ_CW'(ycrgb_pkg::OUTQ_DEPTH);

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + ycrgb_pkg::OUTQ_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + ycrgb_pkg::OUTQ_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + ycrgb_pkg::OUTQ_CW'(push_valid) - ycrgb_pkg::OUTQ_CW'(pop);
      occ_in    = occ_ff + ycrgb_pkg::OUTQ_CW'(in_accept) - ycrgb_pkg::OUTQ_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         q_mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         occ_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         occ_ff    <= occ_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> count_ff < ycrgb_pkg::OUTQ_CW'(ycrgb_pkg::OUTQ_DEPTH))
      else $error("output queue overflow");

   a_count_in_credit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= occ_ff)
      else $error("queued items exceed items in flight");
`endif

endmodule

FILE: hdl/ycbcr_to_rgb_chroma_upsample.sv
`timescale 1ns / 1ps

// an accepted item passes the chroma register, conversion stages a to d and the output queue
// throughput: one item per cycle; the input stalls once 8 items are in flight or queued,
// a limit set by the output queue depth
// reset: synchronous, clears the pixel position, held chroma, pipeline valids, queue
// and registers to their defaults; the chroma line store is not cleared and needs no pass
module ycbcr_to_rgb_chroma_upsample #(
   parameter int MAX_WIDTH     = 4096,
   parameter int MAX_PRECISION = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  ycrgb_pkg::req_payload_type   req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output ycrgb_pkg::rsp_payload_type   rsp_data,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [ycrgb_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   ycrgb_pkg::cfg_type         cfg;
   ycrgb_pkg::pix_type         pix;
   ycrgb_pkg::rsp_payload_type conv_data;
   logic accept, pix_valid, conv_valid, q_full;

   assign req_stall = reset || q_full;
   assign accept    = req_valid && !req_stall;

   ycrgb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ycrgb_chroma #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_chroma (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (accept),
      .in_data   (req_data),
      .out_valid (pix_valid),
      .out_pix   (pix)
   );

   ycrgb_convert #(
      .MAX_PRECISION (MAX_PRECISION)
   ) u_convert (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (pix_valid),
      .in_pix    (pix),
      .out_valid (conv_valid),
      .out_data  (conv_data)
   );

   ycrgb_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .in_accept  (accept),
      .push_valid (conv_valid),
      .push_data  (conv_data),
      .out_valid  (rsp_valid),
      .out_data   (rsp_data),
      .out_stall  (rsp_stall),
      .full       (q_full)
   );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int MAX_LINE = 4096;
   localparam int MAX_BITS = 16;
   localparam int LINE_PAIRS = MAX_LINE / 2;

   localparam longint K_RED_CR   = 91881;
   localparam longint K_GREEN_CB = 22544;
   localparam longint K_GREEN_CR = 46793;
   localparam longint K_BLUE_CB  = 116130;

   localparam int RANDOM_PIXELS = 400;
   localparam int DRAIN_CYCLES  = 20;
   localparam int HOLD_CYCLES   = 80;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   ycrgb_pkg::req_payload_type  req_data = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   ycrgb_pkg::rsp_payload_type  rsp_data;
   logic                        csr_psel = 1'b0;
   logic                        csr_penable = 1'b0;
   logic                        csr_pwrite = 1'b0;
   logic [ycrgb_pkg::CSR_AW-1:0] csr_paddr = '0;
   logic [31:0]                 csr_pwdata = '0;
   logic [31:0]                 csr_prdata;
   logic                        csr_pready;

   ycbcr_to_rgb_chroma_upsample dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state: settings, raster position, chroma pair and line store
   ycrgb_pkg::cfg_type model_cfg = '{ycrgb_pkg::MODE_444, 13'd1, 16'd1, 5'd8, 1'b0, 1'b0};
   int unsigned next_col = 0;
   int unsigned next_row = 0;
   logic [31:0] held_pair = '0;
   logic [31:0] chroma_rows [LINE_PAIRS];

   ycrgb_pkg::rsp_payload_type expected_rgb [$];

   int error_count = 0;
   int pixels_sent = 0;
   int results_checked = 0;
   int pairs_taken = 0;
   int frames_ended = 0;
   int settings_used = 0;
   int send_idle_pct = 36;
   int rsp_idle_pct = 36;
   int hold_left = 0;

   typedef struct packed {
      logic [2:0]                 setting;
      ycrgb_pkg::req_payload_type px;
      logic                       typed;
      ycrgb_pkg::rsp_payload_type want;
   } directed_row_type;

   localparam int N_DIRECTED = 21;

   // setting 0 is the state after reset and is never written
   ycrgb_pkg::cfg_type directed_settings [6] = '{
      '{ycrgb_pkg::MODE_444,  13'd1,    16'd1,     5'd8,  1'b0, 1'b0},
      '{ycrgb_pkg::MODE_420,  13'd2,    16'd3,     5'd8,  1'b1, 1'b0},
      '{ycrgb_pkg::MODE_420,  13'd1,    16'd3,     5'd12, 1'b0, 1'b1},
      '{ycrgb_pkg::MODE_RSVD, 13'd0,    16'd0,     5'd0,  1'b1, 1'b0},
      '{ycrgb_pkg::MODE_422,  13'd8191, 16'd65535, 5'd31, 1'b0, 1'b1},
      '{ycrgb_pkg::MODE_422,  13'd2,    16'd1,     5'd31, 1'b0, 1'b1}
   };
   // last setting shrinks the frame while the position is mid-row
   bit directed_keep [6] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};

   directed_row_type directed_rows [N_DIRECTED] = '{
      '{3'd0, '{16'd0, 16'd128, 16'd128}, 1'b1, '{16'd0, 16'd0, 16'd0, 1'b1, 1'b1}},
      '{3'd0, '{16'd255, 16'd128, 16'd128}, 1'b1, '{16'd255, 16'd255, 16'd255, 1'b1, 1'b1}},
      '{3'd0, '{16'd65535, 16'd0, 16'd0}, 1'b1, '{16'd255, 16'd255, 16'd255, 1'b1, 1'b1}},
      '{3'd0, '{16'd0, 16'd65535, 16'd65535}, 1'b1, '{16'd255, 16'd0, 16'd255, 1'b1, 1'b1}},
      '{3'd0, '{16'd0, 16'd0, 16'd0}, 1'b1, '{16'd0, 16'd135, 16'd0, 1'b1, 1'b1}},
      '{3'd1, '{16'd100, 16'd20, 16'd230}, 1'b0, '0},
      '{3'd1, '{16'd110, 16'd40, 16'd200}, 1'b0, '0},
      '{3'd1, '{16'd120, 16'd60, 16'd180}, 1'b0, '0},
      '{3'd1, '{16'd130, 16'd80, 16'd160}, 1'b0, '0},
      '{3'd1, '{16'd140, 16'd100, 16'd140}, 1'b0, '0},
      '{3'd1, '{16'd150, 16'd240, 16'd16}, 1'b0, '0},
      '{3'd2, '{16'd2048, 16'd4095, 16'd0}, 1'b0, '0},
      '{3'd2, '{16'd1000, 16'd0, 16'd4095}, 1'b0, '0},
      '{3'd2, '{16'd4095, 16'd2048, 16'd2048}, 1'b0, '0},
      '{3'd3, '{16'd1, 16'd1, 16'd0}, 1'b1, '{16'd0, 16'd1, 16'd1, 1'b1, 1'b1}},
      '{3'd3, '{16'd0, 16'd0, 16'd1}, 1'b1, '{16'd0, 16'd0, 16'd0, 1'b1, 1'b1}},
      '{3'd4, '{16'd65535, 16'd65535, 16'd0}, 1'b0, '0},
      '{3'd4, '{16'd0, 16'd0, 16'd65535}, 1'b0, '0},
      '{3'd4, '{16'd32768, 16'd0, 16'd65535}, 1'b0, '0},
      '{3'd5, '{16'd500, 16'd1234, 16'd4321}, 1'b0, '0},
      '{3'd5, '{16'd60000, 16'd32768, 16'd32768}, 1'b0, '0}
   };

   task automatic flag_error(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   function automatic int unsigned effective_bits();
      if (model_cfg.sample_precision == 0) return 1;
      if (model_cfg.sample_precision > MAX_BITS) return MAX_BITS;
      return model_cfg.sample_precision;
   endfunction

   function automatic logic [15:0] clamp_bits(input longint v, input longint top);
      if (v < 0) return '0;
      if (v > top) return 16'(top);
      return 16'(v);
   endfunction

   // steps the raster position and chroma state for one pixel, returns its rgb
   function automatic ycrgb_pkg::rsp_payload_type advance_pixel(
         input ycrgb_pkg::req_payload_type px);
      int unsigned                w, h, p, col, row, cc, rr, idx, offx, offy;
      logic [1:0]                 mode;
      logic [15:0]                cb, cr;
      logic                       taken;
      longint                     off, top, cbs, crs, y;
      ycrgb_pkg::rsp_payload_type r;
      w = model_cfg.line_width;
      if (w == 0) w = 1;
      if (w > MAX_LINE) w = MAX_LINE;
      h = (model_cfg.frame_height == 0) ? 1 : model_cfg.frame_height;
      p = effective_bits();
      mode = (model_cfg.subsampling_mode == ycrgb_pkg::MODE_RSVD) ? ycrgb_pkg::MODE_444 :
             model_cfg.subsampling_mode;
      cb = px.blue_diff;
      cr = px.red_diff;
      taken = 1'b0;

      // a size shrunk under the current position restarts the row or frame
      if (next_col >= w) begin
         next_col = 0;
         next_row++;
      end
      if (next_row >= h) next_row = 0;
      col = next_col;
      row = next_row;

      if (mode == ycrgb_pkg::MODE_444) begin
         taken = 1'b1;
      end else begin
         offx = model_cfg.odd_start_column;
         offy = (mode == ycrgb_pkg::MODE_420) ? model_cfg.odd_start_row : 0;
         if (col < offx || row < offy) begin
            cb = '0;
            cr = '0;
         end else begin
            cc = col - offx;
            rr = row - offy;
            idx = cc / 2;
            if (mode == ycrgb_pkg::MODE_420 && rr % 2 == 1) begin
               {cr, cb} = chroma_rows[idx];
            end else if (cc % 2 == 0) begin
               taken = 1'b1;
               held_pair = {cr, cb};
               if (mode == ycrgb_pkg::MODE_420) chroma_rows[idx] = held_pair;
            end else begin
               {cr, cb} = held_pair;
            end
         end
      end

      off = longint'(1) << (p - 1);
      top = (longint'(1) << p) - 1;
      cbs = longint'(cb) - off;
      crs = longint'(cr) - off;
      y = longint'(px.luma);
      // integer division truncates toward zero, as the q16 products need
      r.red = clamp_bits(y + (K_RED_CR * crs) / 65536, top);
      r.green = clamp_bits(y - (K_GREEN_CB * cbs + K_GREEN_CR * crs) / 65536, top);
      r.blue = clamp_bits(y + (K_BLUE_CB * cbs) / 65536, top);
      r.chroma_taken = taken;
      r.frame_end = (col == w - 1 && row == h - 1);

      next_col++;
      if (next_col >= w) begin
         next_col = 0;
         next_row++;
         if (next_row >= h) next_row = 0;
      end
      return r;
   endfunction

   function automatic void store_setting(input logic [2:0] index, input logic [31:0] value);
      case (index)
         ycrgb_pkg::REG_SUBSAMPLING_MODE: model_cfg.subsampling_mode = value[1:0];
         ycrgb_pkg::REG_LINE_WIDTH:       model_cfg.line_width = value[12:0];
         ycrgb_pkg::REG_FRAME_HEIGHT:     model_cfg.frame_height = value[15:0];
         ycrgb_pkg::REG_SAMPLE_PRECISION: model_cfg.sample_precision = value[4:0];
         ycrgb_pkg::REG_ODD_START_COLUMN: model_cfg.odd_start_column = value[0];
         ycrgb_pkg::REG_ODD_START_ROW:    model_cfg.odd_start_row = value[0];
         default: ;
      endcase
   endfunction

   function automatic logic [31:0] setting_value(input logic [2:0] index);
      case (index)
         ycrgb_pkg::REG_SUBSAMPLING_MODE: return 32'(model_cfg.subsampling_mode);
         ycrgb_pkg::REG_LINE_WIDTH:       return 32'(model_cfg.line_width);
         ycrgb_pkg::REG_FRAME_HEIGHT:     return 32'(model_cfg.frame_height);
         ycrgb_pkg::REG_SAMPLE_PRECISION: return 32'(model_cfg.sample_precision);
         ycrgb_pkg::REG_ODD_START_COLUMN: return 32'(model_cfg.odd_start_column);
         ycrgb_pkg::REG_ODD_START_ROW:    return 32'(model_cfg.odd_start_row);
         default:                         return '0;
      endcase
   endfunction

   // one apb transfer, ended with psel and penable driven low
   task automatic csr_access(input logic [2:0] index, input bit write, input logic [31:0] value,
                             output logic [31:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_verify(input logic [2:0] index);
      logic [31:0] rdata;
      csr_access(index, 1'b0, '0, rdata);
      if (rdata !== setting_value(index))
         flag_error($sformatf("register %0d reads %0h, want %0h", index, rdata,
                              setting_value(index)));
   endtask

   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      logic [31:0] rdata;
      csr_access(index, 1'b1, value, rdata);
      store_setting(index, value);
      csr_verify(index);
   endtask

   function automatic logic [15:0] pick_sample(input int unsigned bits);
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 2) return 16'($urandom);
      if (roll == 2) return 16'((1 << bits) - 1);
      if (roll == 3) return '0;
      return 16'($urandom_range(0, (1 << bits) - 1));
   endfunction

   function automatic ycrgb_pkg::req_payload_type random_pixel();
      ycrgb_pkg::req_payload_type px;
      int unsigned                bits;
      bits = effective_bits();
      px.luma = pick_sample(bits);
      px.blue_diff = pick_sample(bits);
      px.red_diff = pick_sample(bits);
      return px;
   endfunction

   function automatic ycrgb_pkg::cfg_type pick_setting();
      ycrgb_pkg::cfg_type c;
      c.subsampling_mode = ($urandom_range(0, 9) == 0) ? ycrgb_pkg::MODE_RSVD :
                           2'($urandom_range(ycrgb_pkg::MODE_444, ycrgb_pkg::MODE_420));
      case ($urandom_range(0, 9))
         0:       c.line_width = 13'($urandom_range(0, 8191));
         1:       c.line_width = 13'(MAX_LINE);
         default: c.line_width = 13'($urandom_range(1, 9));
      endcase
      case ($urandom_range(0, 9))
         0:       c.frame_height = 16'($urandom);
         1:       c.frame_height = '0;
         default: c.frame_height = 16'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 9))
         0:       c.sample_precision = 5'($urandom);
         1, 2:    c.sample_precision = 5'($urandom_range(1, 7));
         default: c.sample_precision = 5'($urandom_range(8, MAX_BITS));
      endcase
      c.odd_start_column = 1'($urandom);
      c.odd_start_row = 1'($urandom);
      return c;
   endfunction

   // offers one pixel until taken, then records what it should produce
   task automatic issue_pixel(input ycrgb_pkg::req_payload_type px, input logic typed,
                              input ycrgb_pkg::rsp_payload_type typed_want);
      ycrgb_pkg::rsp_payload_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = advance_pixel(px);
      expected_rgb.push_back(typed ? typed_want : predicted);
      pixels_sent++;
   endtask

   task automatic drain_results();
      @(posedge clock);
      while (expected_rgb.size() != 0) @(posedge clock);
   endtask

   task automatic start_phase(input ycrgb_pkg::cfg_type c, input bit keep_pos);
      req_valid <= 1'b0;
      drain_results();
      csr_write(ycrgb_pkg::REG_SUBSAMPLING_MODE, 32'(c.subsampling_mode));
      csr_write(ycrgb_pkg::REG_SAMPLE_PRECISION, 32'(c.sample_precision));
      csr_write(ycrgb_pkg::REG_ODD_START_COLUMN, 32'(c.odd_start_column));
      csr_write(ycrgb_pkg::REG_ODD_START_ROW, 32'(c.odd_start_row));
      if (!keep_pos) begin
         // a one-pixel frame brings the raster position back to the origin,
         // so line store reads always follow writes made under this setting
         csr_write(ycrgb_pkg::REG_LINE_WIDTH, $urandom_range(0, 1));
         csr_write(ycrgb_pkg::REG_FRAME_HEIGHT, $urandom_range(0, 1));
         issue_pixel(random_pixel(), 1'b0, '0);
         req_valid <= 1'b0;
         drain_results();
      end
      csr_write(ycrgb_pkg::REG_LINE_WIDTH, 32'(c.line_width));
      csr_write(ycrgb_pkg::REG_FRAME_HEIGHT, 32'(c.frame_height));
      settings_used++;
   endtask

   // receiver: random stalls, or a counted hold-off
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      ycrgb_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rgb.size() == 0) begin
            flag_error($sformatf("item with nothing expected: %p", rsp_data));
         end else begin
            want = expected_rgb.pop_front();
            if (rsp_data.red !== want.red)
               flag_error($sformatf("red %0h, want %0h", rsp_data.red, want.red));
            if (rsp_data.green !== want.green)
               flag_error($sformatf("green %0h, want %0h", rsp_data.green, want.green));
            if (rsp_data.blue !== want.blue)
               flag_error($sformatf("blue %0h, want %0h", rsp_data.blue, want.blue));
            if (rsp_data.chroma_taken !== want.chroma_taken)
               flag_error($sformatf("chroma_taken %b, want %b", rsp_data.chroma_taken,
                                    want.chroma_taken));
            if (rsp_data.frame_end !== want.frame_end)
               flag_error($sformatf("frame_end %b, want %b", rsp_data.frame_end,
                                    want.frame_end));
            results_checked++;
            pairs_taken += rsp_data.chroma_taken;
            frames_ended += rsp_data.frame_end;
         end
      end
   end

   initial begin
      #2_000_000;
      $display("ERROR: run did not finish in time, %0d items outstanding", expected_rgb.size());
      $display("ycbcr_to_rgb_chroma_upsample regression: fail");
      $finish;
   end

   initial begin
      int unsigned cur_setting;
      int          random_count;
      int          phase_no;
      int          n;
      cur_setting = 0;
      random_count = 0;
      phase_no = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = ycrgb_pkg::REG_SUBSAMPLING_MODE; i <= ycrgb_pkg::REG_ODD_START_ROW; i++)
         csr_verify(3'(i));

      for (int i = 0; i < N_DIRECTED; i++) begin
         if (directed_rows[i].setting != cur_setting) begin
            cur_setting = directed_rows[i].setting;
            start_phase(directed_settings[cur_setting], directed_keep[cur_setting]);
         end
         issue_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].want);
      end

      while (random_count < RANDOM_PIXELS) begin
         start_phase(pick_setting(), 1'b0);
         // phase 2 runs with no idling at all, phase 4 holds the receiver off
         send_idle_pct = (phase_no == 2 || phase_no == 4) ? 0 : 36;
         rsp_idle_pct <= (phase_no == 2) ? 0 : 36;
         n = $urandom_range(30, 60);
         if (phase_no == 4) begin
            hold_left <= HOLD_CYCLES;
            n = 60;
         end
         repeat (n) begin
            issue_pixel(random_pixel(), 1'b0, '0);
            random_count++;
         end
         phase_no++;
      end

      req_valid <= 1'b0;
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d pixels under %0d register settings across all subsampling modes",
               pixels_sent, settings_used);
      $display("checked %0d items: %0d chroma pairs taken, %0d frame ends, %0d errors",
               results_checked, pairs_taken, frames_ended, error_count);
      if (error_count == 0) begin
         $display("ycbcr_to_rgb_chroma_upsample regression: pass");
      end else begin
         $display("ycbcr_to_rgb_chroma_upsample regression: fail");
      end
      $finish;
   end

endmodule
